// ===== design/cic_pkg.sv =====
// Package for the CIC sinc decimator: request codes, fixed widths and the
// command and status structs between controller and datapath. No dependencies.
package cic_pkg;

  localparam int VAL_BITS = 64;
  localparam int SAMPLE_BITS = 32;
  localparam int ORD_W = 2;
  localparam int STAGE_W = 2;
  localparam int BIT_W = $clog2(VAL_BITS);

  localparam logic [1:0] REQ_SAMPLE = 2'd0;
  localparam logic [1:0] REQ_DUMP = 2'd1;
  localparam logic [1:0] REQ_CLR_ALL = 2'd2;
  localparam logic [1:0] REQ_CLR_CNT = 2'd3;

  typedef struct packed {
    logic               load;
    logic               integ_step;
    logic               cnt_inc;
    logic               comb_step;
    logic               div_load;
    logic               div_step;
    logic               div_pass;
    logic               finish;
    logic [STAGE_W-1:0] stage;
  } cmd_t;

  typedef struct packed {
    logic [ORD_W-1:0] ord;
    logic             count_zero;
  } sts_t;

endpackage

// ===== design/cic_if.sv =====
// Valid/ready channel interfaces for the CIC sinc decimator items.
// Depends on cic_pkg for the field widths.
interface cic_in_if import cic_pkg::*;;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    req_type;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output req_type, output sample, input ready);
  modport sink (input valid, input req_type, input sample, output ready);
endinterface

interface cic_out_if import cic_pkg::*;;
  logic                       valid;
  logic                       ready;
  logic signed [VAL_BITS-1:0] filtered_value;
  logic                       divide_error;

  modport source (output valid, output filtered_value, output divide_error, input ready);
  modport sink (input valid, input filtered_value, input divide_error, output ready);
endinterface

// ===== design/cic_sinc_decimator_unit.sv =====
// Sample items load, then take one integrator step per active stage; clear items
// act at the load. Dumps take one comb step per active stage and, when the sample
// count is nonzero, one bit-serial divider pass per active stage (one bit a cycle).
// One item is processed at a time; a held result stalls only a following dump.
// Active-low async reset clears integrators, comb delays and count; order becomes 1.
module cic_sinc_decimator_unit import cic_pkg::*; #(
  parameter int MAX_ORDER = 3,
  parameter int COUNT_BITS = 16,
  parameter int ACC_BITS = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [ORD_W-1:0] cfg_wdata_i,
  cic_in_if.sink           in_i,
  cic_out_if.source        out_o
);

  cmd_t cmd;
  sts_t sts;

  cic_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_req_i    (in_i.req_type),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  cic_dp #(
    .MAX_ORDER  (MAX_ORDER),
    .COUNT_BITS (COUNT_BITS),
    .ACC_BITS   (ACC_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_req_i    (in_i.req_type),
    .in_sample_i (in_i.sample),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_value_o (out_o.filtered_value),
    .out_error_o (out_o.divide_error)
  );

endmodule

// ===== design/cic_ctrl.sv =====
// Controller state machine for the CIC sinc decimator: sequences integrator,
// comb and divider steps. Depends on cic_pkg.
module cic_ctrl import cic_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [1:0] in_req_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  sts_t       sts_i,
  output cmd_t       cmd_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_INTEG = 3'd1;
  localparam logic [2:0] S_COMB = 3'd2;
  localparam logic [2:0] S_DLOAD = 3'd3;
  localparam logic [2:0] S_DIV = 3'd4;
  localparam logic [2:0] S_FIN = 3'd5;

  logic [2:0]         state_q, state_d;
  logic [STAGE_W-1:0] stage_q, stage_d;
  logic [STAGE_W-1:0] pass_q, pass_d;
  logic [BIT_W-1:0]   bit_q, bit_d;
  logic               out_valid_q, out_valid_d;
  logic               last_stage, last_pass, last_bit;

  assign last_stage = stage_q == STAGE_W'(sts_i.ord - ORD_W'(1));
  assign last_pass = pass_q == STAGE_W'(sts_i.ord - ORD_W'(1));
  assign last_bit = bit_q == BIT_W'(VAL_BITS - 1);

  assign in_ready_o = state_q == S_IDLE;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    stage_d = stage_q;
    pass_d = pass_q;
    bit_d = bit_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    cmd_o = '0;
    cmd_o.stage = stage_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          stage_d = '0;
          case (in_req_i)
            REQ_SAMPLE: state_d = S_INTEG;
            REQ_DUMP: state_d = S_COMB;
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_INTEG: begin
        cmd_o.integ_step = 1'b1;
        if (last_stage) begin
          cmd_o.cnt_inc = 1'b1;
          state_d = S_IDLE;
        end else begin
          stage_d = stage_q + STAGE_W'(1);
        end
      end
      S_COMB: begin
        cmd_o.comb_step = 1'b1;
        if (last_stage) begin
          state_d = sts_i.count_zero ? S_FIN : S_DLOAD;
        end else begin
          stage_d = stage_q + STAGE_W'(1);
        end
      end
      S_DLOAD: begin
        cmd_o.div_load = 1'b1;
        bit_d = '0;
        pass_d = '0;
        state_d = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        bit_d = bit_q + BIT_W'(1);
        if (last_bit) begin
          if (last_pass) begin
            state_d = S_FIN;
          end else begin
            cmd_o.div_pass = 1'b1;
            pass_d = pass_q + STAGE_W'(1);
          end
        end
      end
      S_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.finish = 1'b1;
          out_valid_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      stage_q <= '0;
      pass_q <= '0;
      bit_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      stage_q <= stage_d;
      pass_q <= pass_d;
      bit_q <= bit_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== design/cic_dp.sv =====
// Datapath for the CIC sinc decimator: order register, integrators, comb
// delays, sample counter, bit-serial divider and output register. Uses cic_pkg.
module cic_dp import cic_pkg::*; #(
  parameter int MAX_ORDER = 3,
  parameter int COUNT_BITS = 16,
  parameter int ACC_BITS = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ORD_W-1:0]              cfg_wdata_i,
  input  logic [1:0]                    in_req_i,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_i,
  input  cmd_t                          cmd_i,
  output sts_t                          sts_o,
  output logic signed [VAL_BITS-1:0]    out_value_o,
  output logic                          out_error_o
);

  logic [ORD_W-1:0]      order_q;
  logic [ORD_W-1:0]      ord;
  logic [ACC_BITS-1:0]   sums_q [MAX_ORDER];
  logic [ACC_BITS-1:0]   sums_d [MAX_ORDER];
  logic [ACC_BITS-1:0]   dly_q [MAX_ORDER];
  logic [ACC_BITS-1:0]   dly_d [MAX_ORDER];
  logic [ACC_BITS-1:0]   opnd [MAX_ORDER];
  logic [COUNT_BITS-1:0] count_q, count_d;
  logic [ACC_BITS-1:0]   sample_q;
  logic [ACC_BITS-1:0]   carry_q, carry_d;
  logic [ACC_BITS-1:0]   dly_sel;
  logic [VAL_BITS-1:0]   val_ext;
  logic [VAL_BITS-1:0]   dq_q, dq_d;
  logic [COUNT_BITS-1:0] rem_q, rem_d;
  logic [COUNT_BITS:0]   rem_sh;
  logic                  rem_ge;
  logic                  neg_q, neg_d;
  logic [VAL_BITS-1:0]   out_value_q;
  logic                  out_error_q;

  assign ord = (order_q == '0 || int'(order_q) > MAX_ORDER) ? ORD_W'(1) : order_q;
  assign sts_o.ord = ord;
  assign sts_o.count_zero = count_q == '0;

  for (genvar k = 0; k < MAX_ORDER; k++) begin : g_opnd
    if (k == 0) begin : g_first
      assign opnd[k] = sample_q;
    end else begin : g_next
      assign opnd[k] = sums_q[k-1];
    end
  end

  assign val_ext = VAL_BITS'(signed'(carry_q));
  assign rem_sh = {rem_q, dq_q[VAL_BITS-1]};
  assign rem_ge = rem_sh >= {1'b0, count_q};

  always_comb begin
    sums_d = sums_q;
    dly_d = dly_q;
    count_d = count_q;
    carry_d = carry_q;
    dly_sel = '0;
    for (int k = 0; k < MAX_ORDER; k++) begin
      if (cmd_i.stage == STAGE_W'(k)) begin
        dly_sel = dly_q[k];
      end
    end
    if (cmd_i.load) begin
      case (in_req_i)
        REQ_DUMP: begin
          for (int k = 0; k < MAX_ORDER; k++) begin
            if (ord == ORD_W'(k + 1)) begin
              carry_d = sums_q[k];
            end
          end
        end
        REQ_CLR_ALL: begin
          for (int k = 0; k < MAX_ORDER; k++) begin
            sums_d[k] = '0;
            dly_d[k] = '0;
          end
          count_d = '0;
        end
        REQ_CLR_CNT: count_d = '0;
        default: ;
      endcase
    end
    for (int k = 0; k < MAX_ORDER; k++) begin
      if (cmd_i.stage == STAGE_W'(k)) begin
        if (cmd_i.integ_step) begin
          sums_d[k] = sums_q[k] + opnd[k];
        end
        if (cmd_i.comb_step) begin
          dly_d[k] = carry_q;
        end
      end
    end
    if (cmd_i.comb_step) begin
      carry_d = carry_q - dly_sel;
    end
    if (cmd_i.cnt_inc && count_q != '1) begin
      count_d = count_q + COUNT_BITS'(1);
    end
    if (cmd_i.finish) begin
      count_d = '0;
    end
  end

  always_comb begin
    dq_d = dq_q;
    rem_d = rem_q;
    neg_d = neg_q;
    if (cmd_i.div_load) begin
      neg_d = val_ext[VAL_BITS-1];
      dq_d = val_ext[VAL_BITS-1] ? -val_ext : val_ext;
      rem_d = '0;
    end
    if (cmd_i.div_step) begin
      dq_d = {dq_q[VAL_BITS-2:0], rem_ge};
      rem_d = rem_ge ? COUNT_BITS'(rem_sh - {1'b0, count_q}) : COUNT_BITS'(rem_sh);
      if (cmd_i.div_pass) begin
        rem_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q <= ORD_W'(1);
      count_q <= '0;
      for (int k = 0; k < MAX_ORDER; k++) begin
        sums_q[k] <= '0;
        dly_q[k] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        order_q <= cfg_wdata_i;
      end
      count_q <= count_d;
      sums_q <= sums_d;
      dly_q <= dly_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      sample_q <= ACC_BITS'(in_sample_i);
    end
    carry_q <= carry_d;
    dq_q <= dq_d;
    rem_q <= rem_d;
    neg_q <= neg_d;
    if (cmd_i.finish) begin
      out_error_q <= sts_o.count_zero;
      out_value_q <= sts_o.count_zero ? '0 : (neg_q ? -dq_q : dq_q);
    end
  end

  assign out_value_o = signed'(out_value_q);
  assign out_error_o = out_error_q;

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for cic_sinc_decimator_unit: drives sample, dump and clear
// items, predicts each dump result and compares it with what the block returns.
// Depends on cic_pkg and the cic_in_if / cic_out_if channel interfaces.
module testbench import cic_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DRAIN_CYCLES = 240;
  localparam int RAND_PHASE_ITEMS = 175;
  localparam logic [31:0] SAMPLE_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] SAMPLE_MIN = 32'h8000_0000;

  typedef struct packed {
    logic [VAL_BITS-1:0] value;
    logic                div_err;
  } dump_result_t;

  class sinc_scoreboard;
    logic [1:0]          order_q;
    logic [VAL_BITS-1:0] integ_sum [3];
    logic [VAL_BITS-1:0] comb_delay [3];
    logic [15:0]         sample_cnt;
    dump_result_t        expected_dumps [$];
    int unsigned         errors;

    function new();
      order_q = 2'd1;
      errors = 0;
      clear_state();
    endfunction

    function void clear_state();
      for (int k = 0; k < 3; k++) begin
        integ_sum[k] = '0;
        comb_delay[k] = '0;
      end
      sample_cnt = '0;
    endfunction

    function int pending();
      return expected_dumps.size();
    endfunction

    function void accept_item(logic [1:0] req, logic [31:0] smp);
      int                  ord;
      logic [VAL_BITS-1:0] carry;
      logic [VAL_BITS-1:0] prev;
      logic [VAL_BITS-1:0] divisor;
      logic [VAL_BITS-1:0] mag;
      logic [VAL_BITS-1:0] quot;
      dump_result_t        res;
      ord = (order_q == 2'd0) ? 1 : int'(order_q);
      case (req)
        REQ_SAMPLE: begin
          carry = {{32{smp[31]}}, smp};
          for (int k = 0; k < ord; k++) begin
            integ_sum[k] = integ_sum[k] + carry;
            carry = integ_sum[k];
          end
          if (sample_cnt != 16'hFFFF) sample_cnt++;
        end
        REQ_CLR_ALL: begin
          clear_state();
        end
        REQ_CLR_CNT: begin
          sample_cnt = '0;
        end
        default: begin
          carry = integ_sum[ord-1];
          divisor = 64'd1;
          for (int k = 0; k < ord; k++) begin
            prev = comb_delay[k];
            comb_delay[k] = carry;
            carry = carry - prev;
            divisor = divisor * {48'd0, sample_cnt};
          end
          if (sample_cnt == 0) begin
            res.value = '0;
            res.div_err = 1'b1;
          end else begin
            sample_cnt = '0;
            mag = carry[63] ? (64'd0 - carry) : carry;
            quot = mag / divisor;
            res.value = carry[63] ? (64'd0 - quot) : quot;
            res.div_err = 1'b0;
          end
          expected_dumps.push_back(res);
        end
      endcase
    endfunction

    function void check_result(logic [VAL_BITS-1:0] val, logic err);
      dump_result_t want;
      if (expected_dumps.size() == 0) begin
        $error("result item with no expectation: filtered_value %0d divide_error %0b",
               $signed(val), err);
        errors++;
        return;
      end
      want = expected_dumps.pop_front();
      if (val !== want.value) begin
        $error("filtered_value mismatch: expected %0d, actual %0d",
               $signed(want.value), $signed(val));
        errors++;
      end
      if (err !== want.div_err) begin
        $error("divide_error mismatch: expected %0b, actual %0b", want.div_err, err);
        errors++;
      end
    endfunction
  endclass

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [ORD_W-1:0] cfg_wdata_i;
  bit               idle_en;

  sinc_scoreboard sb = new();

  cic_in_if  in_bus ();
  cic_out_if out_bus ();

  cic_sinc_decimator_unit uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_bus.sink),
    .out_o       (out_bus.source)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #50ms;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    int hold;
    hold = 0;
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!idle_en) begin
        out_bus.ready = 1'b1;
      end else if (hold > 0) begin
        out_bus.ready = 1'b0;
        hold--;
      end else if ($urandom_range(5) == 0) begin
        hold = $urandom_range(16, 1) - 1;
        out_bus.ready = 1'b0;
      end else begin
        out_bus.ready = 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      sb.check_result(out_bus.filtered_value, out_bus.divide_error);
    end
  end

  task automatic send_item(input logic [1:0] req, input logic [31:0] smp);
    int gap;
    @(negedge clk_i);
    if (idle_en && $urandom_range(5) == 0) begin
      gap = $urandom_range(16, 1);
      in_bus.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_bus.valid = 1'b1;
    in_bus.req_type = req;
    in_bus.sample = smp;
    do @(posedge clk_i); while (!in_bus.ready);
    sb.accept_item(req, smp);
  endtask

  task automatic settle();
    @(negedge clk_i);
    in_bus.valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_order(input logic [1:0] ord);
    settle();
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_wdata_i = ord;
    @(posedge clk_i);
    sb.order_q = ord;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  function automatic logic [31:0] pick_sample();
    case ($urandom_range(7))
      0: return SAMPLE_MAX;
      1: return SAMPLE_MIN;
      2: return 32'($urandom_range(255));
      3: return 32'hFFFF_FF00 | 32'($urandom_range(255));
      default: return $urandom;
    endcase
  endfunction

  task automatic run_decimation(input int n_items);
    int sent;
    int pick;
    int ratio;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(99);
      if (pick < 4) begin
        send_item(REQ_CLR_ALL, $urandom);
      end else if (pick < 9) begin
        send_item(REQ_CLR_CNT, $urandom);
      end else if (pick < 13) begin
        send_item(REQ_DUMP, $urandom);
      end else begin
        ratio = $urandom_range(24, 1);
        repeat (ratio) send_item(REQ_SAMPLE, pick_sample());
        send_item(REQ_DUMP, $urandom);
        sent += ratio;
      end
      sent++;
    end
  endtask

  initial begin
    logic [1:0] phase_orders [6];
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    in_bus.valid = 1'b0;
    in_bus.req_type = REQ_SAMPLE;
    in_bus.sample = '0;
    idle_en = 1'b1;
    phase_orders = '{2'd2, 2'd3, 2'd0, 2'd1, 2'd3, 2'd2};
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    send_item(REQ_DUMP, 32'h0);
    send_item(REQ_SAMPLE, SAMPLE_MAX);
    send_item(REQ_SAMPLE, SAMPLE_MIN);
    send_item(REQ_SAMPLE, 32'hFFFF_FFFF);
    send_item(REQ_SAMPLE, 32'h0);
    send_item(REQ_DUMP, 32'h0);
    send_item(REQ_CLR_CNT, 32'h0);
    send_item(REQ_DUMP, 32'h0);
    send_item(REQ_SAMPLE, 32'd5);
    send_item(REQ_SAMPLE, -32'sd9);
    send_item(REQ_DUMP, 32'h0);
    send_item(REQ_CLR_ALL, 32'h0);
    send_item(REQ_SAMPLE, 32'd3);
    send_item(REQ_DUMP, 32'h0);
    write_order(2'd3);
    send_item(REQ_SAMPLE, -32'sd100);
    send_item(REQ_SAMPLE, 32'd200);
    send_item(REQ_SAMPLE, SAMPLE_MAX);
    send_item(REQ_DUMP, 32'h0);
    send_item(REQ_DUMP, 32'h0);
    write_order(2'd0);
    send_item(REQ_SAMPLE, SAMPLE_MIN);
    send_item(REQ_DUMP, 32'h0);
    write_order(2'd2);
    send_item(REQ_SAMPLE, 32'd1);
    send_item(REQ_SAMPLE, 32'd2);
    send_item(REQ_DUMP, 32'h0);

    for (int p = 0; p < 6; p++) begin
      write_order(phase_orders[p]);
      idle_en = (p != 2) && (p != 5);
      run_decimation(RAND_PHASE_ITEMS);
    end

    repeat (10) send_item(REQ_SAMPLE, pick_sample());
    send_item(REQ_DUMP, 32'h0);

    settle();
    if (sb.pending() != 0) begin
      $error("%0d expected results never arrived", sb.pending());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
